// ----- src/rss_pkg.sv -----
// ----------------------------------------------------------------------------
// Ratcheting step sequencer package
// Shared constants, codes, state type and helper functions of the sequencer.
// ----------------------------------------------------------------------------
package rss_pkg;

    // Store geometry.
    localparam int STEP_COUNT = 64;
    localparam int SLOT_W     = $clog2(STEP_COUNT);
    localparam int LEN_W      = 7;

    // Input item kinds.
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_PAUSE = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_STEP_PERIOD = 3'd0;
    localparam logic [2:0] CFG_SWING       = 3'd1;
    localparam logic [2:0] CFG_LENGTH      = 3'd2;
    localparam logic [2:0] CFG_ROOT_KEY    = 3'd3;
    localparam logic [2:0] CFG_SCALE       = 3'd4;
    localparam logic [2:0] CFG_CHANNEL     = 3'd5;

    // Step effects.
    localparam logic [2:0] FX_DOUBLE  = 3'd1;
    localparam logic [2:0] FX_TRIPLE  = 3'd2;
    localparam logic [2:0] FX_RND_OCT4 = 3'd3;
    localparam logic [2:0] FX_RND_WIDE = 3'd4;

    // Step trigger conditions.
    localparam logic [2:0] COND_EVERY2 = 3'd1;
    localparam logic [2:0] COND_EVERY3 = 3'd2;
    localparam logic [2:0] COND_EVERY4 = 3'd3;
    localparam logic [2:0] COND_P10    = 3'd4;
    localparam logic [2:0] COND_P25    = 3'd5;
    localparam logic [2:0] COND_P50    = 3'd6;
    localparam logic [2:0] COND_P75    = 3'd7;

    // Event kinds.
    localparam logic EV_NOTE_OFF = 1'b0;
    localparam logic EV_NOTE_ON  = 1'b1;

    // Reciprocals for the shared multiplier. A 27-bit value times RECIP_100
    // shifted right by 34 is its quotient by 100; a 19-bit value times
    // RECIP_3 shifted right by 21 is its quotient by 3. Both are exact over
    // those input ranges.
    localparam logic [27:0] RECIP_100 = 28'd171798692;
    localparam logic [27:0] RECIP_3   = 28'd699051;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_EVAL,
        S_LOAD,
        S_DIV,
        S_DONE,
        S_EMIT
    } state_t;

    // A time is due once the wrapped distance from it is below half the range.
    function automatic logic is_due(input logic [31:0] now, input logic [31:0] t);
        logic [31:0] d;
        d = now - t;
        return ~d[31];
    endfunction

    // Residue of an 8-bit value modulo three, from its base-4 digits.
    function automatic logic [1:0] mod3(input logic [7:0] v);
        logic [3:0] s;
        logic [2:0] r;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        r = 3'(s[3:2]) + 3'(s[1:0]);
        if (r >= 3'd3) r = r - 3'd3;
        if (r >= 3'd3) r = r - 3'd3;
        return r[1:0];
    endfunction

endpackage

// ----- src/ratcheting_step_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// Ratcheting step sequencer core
// Step store, playhead, gate and ratchet timing, trigger conditions and
// random in-scale notes, with one shared multiplier for the swing product and
// the reciprocal divisions.
// ----------------------------------------------------------------------------
// One item at a time. A step write finishes on acceptance. A pause toggle adds
// only its note-off transfer. A tick with no due step passes through the tick
// state to its transfers; a tick that plays a step also evaluates the step and
// runs the swing product and its quotient by 100, and a triple ratchet first
// adds the interval division by 3. Each product or reciprocal division on the
// shared multiplier passes through a load, a multiply and an apply state, and
// the step is read through one register. At most two events leave per item, the last one marked by m_tlast.
module ratcheting_step_sequencer_core
    import rss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    // now_us[31:0], step_slot[37:32], slot_note[44:38], slot_effect[47:45],
    // slot_condition[50:48], rand_percent[57:51], rand_degree[60:58],
    // octave_pick[63:61]
    input  logic [63:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]  s_tuser,
    // Result events.
    output logic        m_tvalid,
    input  logic        m_tready,
    // event_note[6:0], event_channel[10:7]
    output logic [15:0] m_tdata,
    // event_kind[0]
    output logic        m_tuser,
    output logic        m_tlast
);

    // Configuration registers.
    logic [18:0] period_reg;
    logic [6:0]  swing_reg;
    logic [6:0]  length_reg;
    logic [3:0]  root_reg;
    logic [31:0] scale_reg;
    logic [3:0]  channel_reg;

    // Step and counter stores.
    logic [12:0] step_mem [STEP_COUNT];
    logic [7:0]  cnt_mem  [STEP_COUNT];
    logic [12:0] step_rd_reg;
    logic [7:0]  cnt_rd_reg;
    logic [STEP_COUNT-1:0] step_vld_reg;
    logic [STEP_COUNT-1:0] cnt_vld_reg;

    // Sequencer state.
    state_t state_reg, state_next;
    logic [SLOT_W-1:0] playhead_reg;
    logic [6:0]  sounding_reg;
    logic [31:0] next_step_reg, note_off_reg, next_rep_reg;
    logic [1:0]  rep_left_reg;
    logic [18:0] rep_gate_reg, rep_int_reg;
    logic [6:0]  rep_note_reg;
    logic        paused_reg;
    logic        triple_reg;
    logic        frac_reg;

    // Latched item.
    logic [31:0] now_reg;
    logic [6:0]  pct_reg;
    logic [2:0]  deg_reg, oct_reg;

    // Event buffer.
    logic        ev_kind_reg [2];
    logic [6:0]  ev_note_reg [2];
    logic [1:0]  ev_cnt_reg;
    logic        ev_idx_reg;

    // Shared multiplier.
    logic [26:0] mul_a_reg;
    logic [27:0] mul_b_reg;
    logic [54:0] prod_reg;

    logic in_fire, out_fire;
    assign in_fire  = s_tvalid & s_tready;
    assign out_fire = m_tvalid & m_tready;

    // Tick phase: gate expiry and pending ratchet repeats.
    logic       off_due, rep_fire, step_go;
    logic [6:0] snd_after;
    logic [1:0] rep_after;
    always_comb begin
        off_due   = (sounding_reg != 7'd0) && is_due(now_reg, note_off_reg);
        snd_after = off_due ? 7'd0 : sounding_reg;
        rep_fire  = (rep_left_reg != 2'd0) && (snd_after == 7'd0) &&
                    is_due(now_reg, next_rep_reg);
        rep_after = rep_fire ? rep_left_reg - 2'd1 : rep_left_reg;
        if (rep_fire) snd_after = rep_note_reg;
        step_go   = !paused_reg && (snd_after == 7'd0) && (rep_after == 2'd0) &&
                    is_due(now_reg, next_step_reg);
    end

    // Step evaluation: condition, note choice and swing share.
    logic [6:0]  st_note;
    logic [2:0]  st_fx, st_cond;
    logic [7:0]  st_cnt;
    logic        play, cnt_bump;
    logic [3:0]  sc_off;
    logic [2:0]  oct_c;
    logic [6:0]  pn;
    logic [6:0]  swing_c, share;
    logic [6:0]  len_eff;
    logic [LEN_W-1:0] ph_inc;
    always_comb begin
        {st_cond, st_fx, st_note} = step_vld_reg[playhead_reg] ? step_rd_reg : 13'd0;
        st_cnt   = cnt_vld_reg[playhead_reg] ? cnt_rd_reg : 8'd0;
        play     = 1'b1;
        cnt_bump = 1'b0;
        if (st_note != 7'd0) begin
            case (st_cond)
                COND_EVERY2: begin play = (st_cnt[0] == 1'b0);     cnt_bump = 1'b1; end
                COND_EVERY3: begin play = (mod3(st_cnt) == 2'd0);  cnt_bump = 1'b1; end
                COND_EVERY4: begin play = (st_cnt[1:0] == 2'd0);   cnt_bump = 1'b1; end
                COND_P10:    play = pct_reg < 7'd10;
                COND_P25:    play = pct_reg < 7'd25;
                COND_P50:    play = pct_reg < 7'd50;
                COND_P75:    play = pct_reg < 7'd75;
                default:     play = 1'b1;
            endcase
        end
        sc_off = scale_reg[{deg_reg, 2'b00} +: 4];
        oct_c  = (oct_reg < 3'd3) ? 3'd3 : ((oct_reg > 3'd5) ? 3'd5 : oct_reg);
        case (st_fx)
            FX_RND_OCT4: pn = 7'(root_reg) + 7'd48 + 7'(sc_off);
            FX_RND_WIDE: pn = 7'(root_reg) + {1'b0, oct_c, 3'b000} + {2'b00, oct_c, 2'b00}
                              + 7'(sc_off);
            default:     pn = st_note;
        endcase
        swing_c = (swing_reg > 7'd100) ? 7'd100 : swing_reg;
        share   = playhead_reg[0] ? 7'd100 - swing_c : swing_c;
        len_eff = (length_reg == 7'd0) ? 7'd1 :
                  ((length_reg > 7'(STEP_COUNT)) ? 7'(STEP_COUNT) : length_reg);
        ph_inc  = LEN_W'(playhead_reg) + 7'd1;
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    if (s_tuser == MODE_TICK) state_next = S_TICK;
                    else if (s_tuser == MODE_PAUSE && !paused_reg && sounding_reg != 7'd0)
                        state_next = S_EMIT;
                end
            end
            S_TICK: begin
                if (step_go) state_next = S_EVAL;
                else if (off_due || rep_fire) state_next = S_EMIT;
                else state_next = S_IDLE;
            end
            S_EVAL: state_next = S_LOAD;
            S_LOAD: state_next = S_DIV;
            S_DIV:  state_next = S_DONE;
            S_DONE: begin
                if (triple_reg || !frac_reg) state_next = S_LOAD;
                else if (ev_cnt_reg != 2'd0) state_next = S_EMIT;
                else state_next = S_IDLE;
            end
            S_EMIT: if (out_fire && (2'(ev_idx_reg) + 2'd1 == ev_cnt_reg)) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Port outputs.
    always_comb begin
        s_tready = (state_reg == S_IDLE);
        m_tvalid = (state_reg == S_EMIT);
        m_tuser  = ev_kind_reg[ev_idx_reg];
        m_tdata  = {5'd0, channel_reg, ev_note_reg[ev_idx_reg]};
        m_tlast  = (2'(ev_idx_reg) + 2'd1 == ev_cnt_reg);
    end

    // Step store: written by write items, read at the playhead.
    always_ff @(posedge aclk) begin
        if (in_fire && s_tuser == MODE_WRITE)
            step_mem[s_tdata[37:32]] <= s_tdata[50:38];
        step_rd_reg <= step_mem[playhead_reg];
    end

    // Trigger counter store.
    always_ff @(posedge aclk) begin
        if (state_reg == S_EVAL && cnt_bump)
            cnt_mem[playhead_reg] <= st_cnt + 8'd1;
        cnt_rd_reg <= cnt_mem[playhead_reg];
    end

    // Control state, configuration and datapath.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            period_reg    <= 19'd125000;
            swing_reg     <= 7'd50;
            length_reg    <= 7'd64;
            root_reg      <= 4'd0;
            scale_reg     <= 32'd3415692320;
            channel_reg   <= 4'd0;
            step_vld_reg  <= '0;
            cnt_vld_reg   <= '0;
            playhead_reg  <= '0;
            sounding_reg  <= 7'd0;
            next_step_reg <= 32'd0;
            note_off_reg  <= 32'd0;
            next_rep_reg  <= 32'd0;
            rep_left_reg  <= 2'd0;
            rep_gate_reg  <= 19'd0;
            rep_int_reg   <= 19'd0;
            rep_note_reg  <= 7'd0;
            paused_reg    <= 1'b1;
            triple_reg    <= 1'b0;
            frac_reg      <= 1'b0;
            ev_cnt_reg    <= 2'd0;
            ev_idx_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            // The user must write configuration only while idle; the block does not enforce it.
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_STEP_PERIOD: period_reg  <= cfg_wdata[18:0];
                    CFG_SWING:       swing_reg   <= cfg_wdata[6:0];
                    CFG_LENGTH: begin
                        length_reg <= cfg_wdata[6:0];
                        if (LEN_W'(playhead_reg) >= ((cfg_wdata[6:0] == 7'd0) ? 7'd1 :
                            ((cfg_wdata[6:0] > 7'(STEP_COUNT)) ? 7'(STEP_COUNT) :
                             cfg_wdata[6:0])))
                            playhead_reg <= '0;
                    end
                    CFG_ROOT_KEY:    root_reg    <= cfg_wdata[3:0];
                    CFG_SCALE:       scale_reg   <= cfg_wdata;
                    CFG_CHANNEL:     channel_reg <= cfg_wdata[3:0];
                    default: ;
                endcase
            end

            case (state_reg)
                // Take an item; writes, and pause toggles apart from their note-off, finish here.
                S_IDLE: begin
                    if (in_fire) begin
                        now_reg    <= s_tdata[31:0];
                        pct_reg    <= s_tdata[57:51];
                        deg_reg    <= s_tdata[60:58];
                        oct_reg    <= s_tdata[63:61];
                        ev_cnt_reg <= 2'd0;
                        ev_idx_reg <= 1'b0;
                        if (s_tuser == MODE_WRITE) begin
                            step_vld_reg[s_tdata[37:32]] <= 1'b1;
                        end else if (s_tuser == MODE_PAUSE) begin
                            paused_reg <= !paused_reg;
                            if (!paused_reg && sounding_reg != 7'd0) begin
                                ev_kind_reg[0] <= EV_NOTE_OFF;
                                ev_note_reg[0] <= sounding_reg;
                                ev_cnt_reg     <= 2'd1;
                                sounding_reg   <= 7'd0;
                            end
                        end
                    end
                end
                // End an expired gate and fire a due repeat.
                S_TICK: begin
                    sounding_reg <= snd_after;
                    rep_left_reg <= rep_after;
                    if (off_due) begin
                        ev_kind_reg[0] <= EV_NOTE_OFF;
                        ev_note_reg[0] <= sounding_reg;
                    end
                    if (rep_fire) begin
                        ev_kind_reg[off_due] <= EV_NOTE_ON;
                        ev_note_reg[off_due] <= rep_note_reg;
                        note_off_reg <= now_reg + 32'(rep_gate_reg);
                        next_rep_reg <= now_reg + 32'(rep_int_reg);
                    end
                    ev_cnt_reg <= 2'(off_due) + 2'(rep_fire);
                end
                // Play the step under the playhead.
                S_EVAL: begin
                    if (cnt_bump) cnt_vld_reg[playhead_reg] <= 1'b1;
                    triple_reg <= 1'b0;
                    frac_reg   <= 1'b0;
                    if (st_note != 7'd0 && play) begin
                        sounding_reg <= pn;
                        rep_left_reg <= 2'd0;
                        ev_kind_reg[ev_cnt_reg[0]] <= EV_NOTE_ON;
                        ev_note_reg[ev_cnt_reg[0]] <= pn;
                        ev_cnt_reg <= ev_cnt_reg + 2'd1;
                        note_off_reg <= now_reg + 32'(period_reg[18:1]);
                        if (st_fx == FX_DOUBLE) begin
                            rep_int_reg  <= 19'(period_reg[18:1]);
                            rep_gate_reg <= 19'(period_reg[18:2]);
                            rep_left_reg <= 2'd1;
                            rep_note_reg <= pn;
                            next_rep_reg <= now_reg + 32'(period_reg[18:1]);
                            note_off_reg <= now_reg + 32'(period_reg[18:2]);
                        end else if (st_fx == FX_TRIPLE) begin
                            rep_left_reg <= 2'd2;
                            rep_note_reg <= pn;
                            triple_reg   <= 1'b1;
                        end
                    end
                end
                // Pick the operands: triple interval, then swing product,
                // then the product's quotient by 100.
                S_LOAD: begin
                    if (triple_reg) begin
                        mul_a_reg <= 27'(period_reg);
                        mul_b_reg <= RECIP_3;
                    end else if (!frac_reg) begin
                        mul_a_reg <= 27'({share, 1'b0});
                        mul_b_reg <= 28'(period_reg);
                    end else begin
                        mul_a_reg <= prod_reg[26:0];
                        mul_b_reg <= RECIP_100;
                    end
                end
                S_DIV: prod_reg <= 55'(mul_a_reg) * 55'(mul_b_reg);
                // Apply a product.
                S_DONE: begin
                    if (triple_reg) begin
                        triple_reg   <= 1'b0;
                        rep_int_reg  <= prod_reg[39:21];
                        rep_gate_reg <= {1'b0, prod_reg[39:22]};
                        next_rep_reg <= now_reg + 32'(prod_reg[39:21]);
                        note_off_reg <= now_reg + 32'(prod_reg[39:22]);
                    end else if (!frac_reg) begin
                        frac_reg <= 1'b1;
                    end else begin
                        frac_reg      <= 1'b0;
                        next_step_reg <= now_reg + 32'(prod_reg[54:34]);
                        playhead_reg  <= (ph_inc >= len_eff) ? '0 : ph_inc[SLOT_W-1:0];
                    end
                end
                // Hand out the buffered events.
                S_EMIT: if (out_fire) ev_idx_reg <= ev_idx_reg + 1'b1;
                default: ;
            endcase
        end
    end

endmodule
